// ===== hw/rtl/tkds_pkg.sv =====
`timescale 1ns / 1ps

package tkds_pkg;

  localparam int unsigned CAPACITY = 20;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned RANK_W   = 5;
  localparam int unsigned NAME_W   = 64;
  localparam int unsigned NAME_WORDS = 4;

  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_DUMP   = 2'd2;

  typedef logic [NAME_WORDS-1:0][NAME_W-1:0] name_t;

  typedef struct packed {
    name_t              name;
    logic signed [7:0]  strength;
    logic [7:0]         chan;
    logic [31:0]        flags;
  } entry_t;

  typedef enum logic [2:0] {
    CELL_KEEP,
    CELL_NEW,
    CELL_LEFT,
    CELL_RIGHT,
    CELL_HEAD
  } cell_op_e;

  typedef struct packed {
    logic     cmp_en;
    cell_op_e op;
  } cell_ctrl_t;

  // Everything after the first zero byte of a name is forced to zero.
  function automatic name_t canon_name(input name_t raw);
    name_t      res;
    logic       ended;
    logic [7:0] byte_v;
    res   = '0;
    ended = 1'b0;
    for (int w = 0; w < NAME_WORDS; w++) begin
      for (int b = 0; b < 8; b++) begin
        byte_v = raw[w][8*b +: 8];
        if (byte_v == 8'd0) begin
          ended = 1'b1;
        end
        if (!ended) begin
          res[w][8*b +: 8] = byte_v;
        end
      end
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/tkds_cell.sv =====
`timescale 1ns / 1ps

module tkds_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tkds_pkg::cell_ctrl_t ctrl_i,
  input  logic                valid_i,
  input  tkds_pkg::entry_t    new_i,
  input  tkds_pkg::entry_t    left_i,
  input  tkds_pkg::entry_t    right_i,
  input  tkds_pkg::entry_t    head_i,
  output tkds_pkg::entry_t    entry_o,
  output logic                match_o,
  output logic                ge_o
);

  tkds_pkg::entry_t entry_q, entry_d;
  logic match_q, match_d;
  logic ge_q, ge_d;

  always_comb begin
    match_d = match_q;
    ge_d    = ge_q;
    if (ctrl_i.cmp_en) begin
      match_d = valid_i && (entry_q.name == new_i.name);
      ge_d    = valid_i && ($signed(entry_q.strength) >= $signed(new_i.strength));
    end
  end

  always_comb begin
    unique case (ctrl_i.op)
      tkds_pkg::CELL_KEEP:  entry_d = entry_q;
      tkds_pkg::CELL_NEW:   entry_d = new_i;
      tkds_pkg::CELL_LEFT:  entry_d = left_i;
      tkds_pkg::CELL_RIGHT: entry_d = right_i;
      tkds_pkg::CELL_HEAD:  entry_d = head_i;
      default:              entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
      ge_q    <= 1'b0;
    end else begin
      match_q <= match_d;
      ge_q    <= ge_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign match_o = match_q;
  assign ge_o    = ge_q;

endmodule

// ===== hw/rtl/top_k_dedup_sorted_insert_unit.sv =====
`timescale 1ns / 1ps

// A row of CAPACITY cells holds the table in rank order, one entry per cell.
// Clear finishes when it is accepted. Insert goes through accept, a compare
// state in which every cell checks the name and strength against the new
// item, and an update state in which the cells shift one place toward the
// back to open a slot at the insert position. Dump rotates the row one place
// per result and sends cell 0 out, one result per stored entry (a single
// empty result for an empty table), waits while the output is stalled, and
// leaves the row in its original order. A new item is taken only when the
// previous one has finished its work; a finished result may still wait in the
// output register.
module top_k_dedup_sorted_insert_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         action_i,
  input  logic [63:0]        name_word0_i,
  input  logic [63:0]        name_word1_i,
  input  logic [63:0]        name_word2_i,
  input  logic [63:0]        name_word3_i,
  input  logic signed [7:0]  strength_i,
  input  logic [7:0]         chan_i,
  input  logic [31:0]        sec_flags_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [63:0]        out_name_word0_o,
  output logic [63:0]        out_name_word1_o,
  output logic [63:0]        out_name_word2_o,
  output logic [63:0]        out_name_word3_o,
  output logic signed [7:0]  out_strength_o,
  output logic [7:0]         out_chan_o,
  output logic [31:0]        out_sec_flags_o,
  output logic [4:0]         rank_o,
  output logic               entry_valid_o,
  output logic               last_o
);

  localparam int unsigned CAP = tkds_pkg::CAPACITY;
  localparam int unsigned CW  = tkds_pkg::CNT_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;
  localparam logic [1:0] ST_DUMP = 2'd3;

  logic [1:0] st_q, st_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;

  tkds_pkg::entry_t new_q, new_d;
  logic nonempty_q, nonempty_d;

  tkds_pkg::entry_t out_q, out_d;
  logic [tkds_pkg::RANK_W-1:0] rank_q, rank_d;
  logic ev_q, ev_d;
  logic last_q, last_d;
  logic ovalid_q, ovalid_d;

  tkds_pkg::entry_t   cell_ent [CAP];
  tkds_pkg::cell_ctrl_t cell_ctrl [CAP];
  logic [CAP-1:0] match_v, ge_v, ge_prev, le_hole, valid_v, new_sel;
  logic any_match, do_ins, in_acc, out_free, dump_last;
  tkds_pkg::name_t raw_name;

  assign in_ready_o = (st_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !ovalid_q || out_ready_i;
  assign raw_name   = {name_word3_i, name_word2_i, name_word1_i, name_word0_i};

  for (genvar j = 0; j < CAP; j++) begin : g_valid
    assign valid_v[j] = (CW'(j) < count_q);
  end

  assign ge_prev   = {ge_v[CAP-2:0], 1'b1};
  assign any_match = |match_v;
  assign dump_last = (idx_q == count_q - CW'(1));

  always_comb begin
    if (any_match) begin
      le_hole[CAP-1] = match_v[CAP-1];
      for (int j = CAP - 2; j >= 0; j--) begin
        le_hole[j] = le_hole[j+1] | match_v[j];
      end
    end else if (count_q < CW'(CAP)) begin
      for (int j = 0; j < CAP; j++) begin
        le_hole[j] = (CW'(j) <= count_q);
      end
    end else begin
      le_hole = '1;
    end
  end

  always_comb begin
    if (!nonempty_q) begin
      do_ins = 1'b0;
    end else if (any_match) begin
      do_ins = |(match_v & ~ge_v);
    end else begin
      do_ins = (count_q < CW'(CAP)) || !ge_v[CAP-1];
    end
  end

  always_comb begin
    for (int j = 0; j < CAP; j++) begin
      cell_ctrl[j].cmp_en = (st_q == ST_CMP);
      cell_ctrl[j].op     = tkds_pkg::CELL_KEEP;
      new_sel[j]          = 1'b0;
      if (st_q == ST_UPD && do_ins && !ge_v[j] && le_hole[j]) begin
        if (ge_prev[j]) begin
          cell_ctrl[j].op = tkds_pkg::CELL_NEW;
          new_sel[j]      = 1'b1;
        end else begin
          cell_ctrl[j].op = tkds_pkg::CELL_LEFT;
        end
      end else if (st_q == ST_DUMP && out_free && valid_v[j]) begin
        if (CW'(j) == count_q - CW'(1)) begin
          cell_ctrl[j].op = tkds_pkg::CELL_HEAD;
        end else begin
          cell_ctrl[j].op = tkds_pkg::CELL_RIGHT;
        end
      end
    end
  end

  for (genvar j = 0; j < CAP; j++) begin : g_cell
    tkds_pkg::entry_t left_e, right_e;
    if (j == 0) begin : g_first
      assign left_e = new_q;
    end else begin : g_mid_l
      assign left_e = cell_ent[j-1];
    end
    if (j == CAP - 1) begin : g_end
      assign right_e = cell_ent[0];
    end else begin : g_mid_r
      assign right_e = cell_ent[j+1];
    end
    tkds_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (cell_ctrl[j]),
      .valid_i (valid_v[j]),
      .new_i   (new_q),
      .left_i  (left_e),
      .right_i (right_e),
      .head_i  (cell_ent[0]),
      .entry_o (cell_ent[j]),
      .match_o (match_v[j]),
      .ge_o    (ge_v[j])
    );
  end

  always_comb begin
    st_d       = st_q;
    count_d    = count_q;
    idx_d      = idx_q;
    new_d      = new_q;
    nonempty_d = nonempty_q;
    out_d      = out_q;
    rank_d     = rank_q;
    ev_d       = ev_q;
    last_d     = last_q;
    ovalid_d   = ovalid_q && !out_ready_i;

    unique case (st_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (action_i)
            tkds_pkg::ACT_CLEAR: begin
              count_d = '0;
            end
            tkds_pkg::ACT_INSERT: begin
              new_d.name     = tkds_pkg::canon_name(raw_name);
              new_d.strength = strength_i;
              new_d.chan     = chan_i;
              new_d.flags    = sec_flags_i;
              nonempty_d     = (name_word0_i[7:0] != 8'd0);
              st_d           = ST_CMP;
            end
            tkds_pkg::ACT_DUMP: begin
              idx_d = '0;
              st_d  = ST_DUMP;
            end
            default: begin
            end
          endcase
        end
      end
      ST_CMP: begin
        st_d = ST_UPD;
      end
      ST_UPD: begin
        if (do_ins && !any_match && count_q < CW'(CAP)) begin
          count_d = count_q + CW'(1);
        end
        st_d = ST_IDLE;
      end
      ST_DUMP: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          if (count_q == '0) begin
            out_d  = '0;
            rank_d = '0;
            ev_d   = 1'b0;
            last_d = 1'b1;
            st_d   = ST_IDLE;
          end else begin
            out_d  = cell_ent[0];
            rank_d = tkds_pkg::RANK_W'(idx_q);
            ev_d   = 1'b1;
            last_d = dump_last;
            idx_d  = idx_q + CW'(1);
            if (dump_last) begin
              st_d = ST_IDLE;
            end
          end
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      count_q  <= '0;
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      count_q  <= count_d;
      idx_q    <= idx_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    new_q      <= new_d;
    nonempty_q <= nonempty_d;
    out_q      <= out_d;
    rank_q     <= rank_d;
    ev_q       <= ev_d;
    last_q     <= last_d;
  end

  assign out_valid_o      = ovalid_q;
  assign out_name_word0_o = out_q.name[0];
  assign out_name_word1_o = out_q.name[1];
  assign out_name_word2_o = out_q.name[2];
  assign out_name_word3_o = out_q.name[3];
  assign out_strength_o   = out_q.strength;
  assign out_chan_o       = out_q.chan;
  assign out_sec_flags_o  = out_q.flags;
  assign rank_o           = rank_q;
  assign entry_valid_o    = ev_q;
  assign last_o           = last_q;

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAP))
    else $error("entry count exceeds capacity");

  a_single_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_UPD |-> $onehot0(match_v))
    else $error("name found in more than one cell");

  a_single_new: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(new_sel))
    else $error("new item written to more than one cell");

  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && !ev_q |-> last_q)
    else $error("empty-table result not marked last");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != $past(count_q) |-> count_q == '0 || count_q == $past(count_q) + CW'(1))
    else $error("entry count changed by an illegal step");
`endif

endmodule

// ===== tb/tkds_table_checker.sv =====
`timescale 1ns / 1ps

module tkds_table_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [1:0]         action_i,
  input  logic [63:0]        name_word0_i,
  input  logic [63:0]        name_word1_i,
  input  logic [63:0]        name_word2_i,
  input  logic [63:0]        name_word3_i,
  input  logic signed [7:0]  strength_i,
  input  logic [7:0]         chan_i,
  input  logic [31:0]        sec_flags_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [63:0]        out_name_word0_i,
  input  logic [63:0]        out_name_word1_i,
  input  logic [63:0]        out_name_word2_i,
  input  logic [63:0]        out_name_word3_i,
  input  logic signed [7:0]  out_strength_i,
  input  logic [7:0]         out_chan_i,
  input  logic [31:0]        out_sec_flags_i,
  input  logic [4:0]         rank_i,
  input  logic               entry_valid_i,
  input  logic               last_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct {
    tkds_pkg::entry_t ent;
    logic [4:0]       rank;
    logic             valid;
    logic             last;
  } dump_row_t;

  tkds_pkg::entry_t slots [tkds_pkg::CAPACITY];
  int               live_count = 0;
  dump_row_t        dump_rows_q [$];
  dump_row_t        want_row;
  int               n_fail = 0;

  function automatic tkds_pkg::name_t trim_name(input tkds_pkg::name_t raw);
    logic [255:0] flat;
    logic [255:0] res;
    bit           stop;
    flat = raw;
    res  = '0;
    stop = 1'b0;
    for (int k = 0; k < 32; k++) begin
      if (flat[8*k +: 8] == 8'h00) begin
        stop = 1'b1;
      end
      if (!stop) begin
        res[8*k +: 8] = flat[8*k +: 8];
      end
    end
    return res;
  endfunction

  // Ties do not move, so equal strengths keep their older order.
  function automatic void promote(input int pos);
    tkds_pkg::entry_t tmp;
    while (pos > 0 && slots[pos].strength > slots[pos-1].strength) begin
      tmp           = slots[pos];
      slots[pos]    = slots[pos-1];
      slots[pos-1]  = tmp;
      pos--;
    end
  endfunction

  function automatic void insert_entry(input tkds_pkg::entry_t e);
    int hit;
    hit = -1;
    if (e.name[0][7:0] == 8'h00) begin
      return;
    end
    for (int k = 0; k < live_count; k++) begin
      if (hit < 0 && slots[k].name == e.name) begin
        hit = k;
      end
    end
    if (hit >= 0) begin
      if (e.strength > slots[hit].strength) begin
        slots[hit] = e;
        promote(hit);
      end
    end else if (live_count >= tkds_pkg::CAPACITY) begin
      if (e.strength > slots[tkds_pkg::CAPACITY-1].strength) begin
        slots[tkds_pkg::CAPACITY-1] = e;
        promote(tkds_pkg::CAPACITY - 1);
      end
    end else begin
      slots[live_count] = e;
      live_count++;
      promote(live_count - 1);
    end
  endfunction

  function automatic void apply_action(input logic [1:0] act,
                                       input tkds_pkg::name_t raw,
                                       input logic signed [7:0] s, input logic [7:0] c,
                                       input logic [31:0] f);
    tkds_pkg::entry_t e;
    dump_row_t        row;
    case (act)
      tkds_pkg::ACT_CLEAR: begin
        live_count = 0;
      end
      tkds_pkg::ACT_INSERT: begin
        e.name     = trim_name(raw);
        e.strength = s;
        e.chan     = c;
        e.flags    = f;
        insert_entry(e);
      end
      tkds_pkg::ACT_DUMP: begin
        if (live_count == 0) begin
          row.ent   = '0;
          row.rank  = '0;
          row.valid = 1'b0;
          row.last  = 1'b1;
          dump_rows_q.push_back(row);
        end else begin
          for (int k = 0; k < live_count; k++) begin
            row.ent   = slots[k];
            row.rank  = 5'(k);
            row.valid = 1'b1;
            row.last  = (k == live_count - 1);
            dump_rows_q.push_back(row);
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic int field_diff(input string label, input logic [63:0] want,
                                    input logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", label, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (dump_rows_q.size() == 0) begin
          $error("Result item with no expectation pending (rank %0d).", rank_i);
          n_fail++;
        end else begin
          want_row = dump_rows_q.pop_front();
          n_fail += field_diff("out_name_word0", want_row.ent.name[0], out_name_word0_i);
          n_fail += field_diff("out_name_word1", want_row.ent.name[1], out_name_word1_i);
          n_fail += field_diff("out_name_word2", want_row.ent.name[2], out_name_word2_i);
          n_fail += field_diff("out_name_word3", want_row.ent.name[3], out_name_word3_i);
          n_fail += field_diff("out_strength", {56'd0, want_row.ent.strength},
                               {56'd0, out_strength_i});
          n_fail += field_diff("out_chan", {56'd0, want_row.ent.chan}, {56'd0, out_chan_i});
          n_fail += field_diff("out_sec_flags", {32'd0, want_row.ent.flags},
                               {32'd0, out_sec_flags_i});
          n_fail += field_diff("rank", {59'd0, want_row.rank}, {59'd0, rank_i});
          n_fail += field_diff("entry_valid", {63'd0, want_row.valid}, {63'd0, entry_valid_i});
          n_fail += field_diff("last", {63'd0, want_row.last}, {63'd0, last_i});
        end
      end
      if (in_valid_i && in_ready_i) begin
        apply_action(action_i, {name_word3_i, name_word2_i, name_word1_i, name_word0_i},
                     strength_i, chan_i, sec_flags_i);
      end
      fail_count_o <= n_fail;
      pending_o    <= dump_rows_q.size();
    end
  end

endmodule

// ===== tb/tb_top_k_dedup_sorted_insert_unit.sv =====
`timescale 1ns / 1ps

module tb_top_k_dedup_sorted_insert_unit;

  localparam int POOL_N       = 40;
  localparam int RANDOM_ITEMS = 200;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 4000;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         action;
  logic [63:0]        name_word0;
  logic [63:0]        name_word1;
  logic [63:0]        name_word2;
  logic [63:0]        name_word3;
  logic signed [7:0]  strength;
  logic [7:0]         chan;
  logic [31:0]        sec_flags;
  logic               out_valid;
  logic               out_ready;
  logic [63:0]        out_name_word0;
  logic [63:0]        out_name_word1;
  logic [63:0]        out_name_word2;
  logic [63:0]        out_name_word3;
  logic signed [7:0]  out_strength;
  logic [7:0]         out_chan;
  logic [31:0]        out_sec_flags;
  logic [4:0]         rank;
  logic               entry_valid;
  logic               last;

  int              fail_count;
  int              pending;
  tkds_pkg::name_t pool [POOL_N];
  int              pool_len [POOL_N];
  int              n_sent = 0;
  bit              gaps_on = 1'b1;
  bit              hold_req = 1'b0;
  bit              hold_done = 1'b0;

  top_k_dedup_sorted_insert_unit DUT (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .action_i         (action),
    .name_word0_i     (name_word0),
    .name_word1_i     (name_word1),
    .name_word2_i     (name_word2),
    .name_word3_i     (name_word3),
    .strength_i       (strength),
    .chan_i           (chan),
    .sec_flags_i      (sec_flags),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .out_name_word0_o (out_name_word0),
    .out_name_word1_o (out_name_word1),
    .out_name_word2_o (out_name_word2),
    .out_name_word3_o (out_name_word3),
    .out_strength_o   (out_strength),
    .out_chan_o       (out_chan),
    .out_sec_flags_o  (out_sec_flags),
    .rank_o           (rank),
    .entry_valid_o    (entry_valid),
    .last_o           (last)
  );

  tkds_table_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .action_i         (action),
    .name_word0_i     (name_word0),
    .name_word1_i     (name_word1),
    .name_word2_i     (name_word2),
    .name_word3_i     (name_word3),
    .strength_i       (strength),
    .chan_i           (chan),
    .sec_flags_i      (sec_flags),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_name_word0_i (out_name_word0),
    .out_name_word1_i (out_name_word1),
    .out_name_word2_i (out_name_word2),
    .out_name_word3_i (out_name_word3),
    .out_strength_i   (out_strength),
    .out_chan_i       (out_chan),
    .out_sec_flags_i  (out_sec_flags),
    .rank_i           (rank),
    .entry_valid_i    (entry_valid),
    .last_i           (last),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Bytes after the terminator are filled with junk half of the time.
  function automatic tkds_pkg::name_t dress_name(input tkds_pkg::name_t canon, input int len);
    logic [255:0] flat;
    flat = canon;
    if (len < 32 && $urandom_range(0, 1) == 1) begin
      for (int k = len + 1; k < 32; k++) begin
        flat[8*k +: 8] = 8'($urandom);
      end
    end
    return flat;
  endfunction

  function automatic tkds_pkg::name_t noise_name();
    return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  task automatic send_item(input logic [1:0] act, input tkds_pkg::name_t nm,
                           input logic signed [7:0] s, input logic [7:0] c,
                           input logic [31:0] f);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    action     <= act;
    name_word0 <= nm[0];
    name_word1 <= nm[1];
    name_word2 <= nm[2];
    name_word3 <= nm[3];
    strength   <= s;
    chan       <= c;
    sec_flags  <= f;
    do @(posedge clk); while (!in_ready);
    n_sent++;
  endtask

  task automatic send_cmd(input logic [1:0] act);
    send_item(act, noise_name(), 8'($urandom), 8'($urandom), $urandom);
  endtask

  task automatic insert_pool(input int idx, input logic signed [7:0] s);
    send_item(tkds_pkg::ACT_INSERT, dress_name(pool[idx], pool_len[idx]), s,
              8'($urandom), $urandom);
  endtask

  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
        out_ready <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    logic [255:0]      flat;
    int                len;
    int                n_ins;
    int                pick;
    logic signed [7:0] s;

    rst_n      = 1'b0;
    in_valid   = 1'b0;
    action     = tkds_pkg::ACT_CLEAR;
    name_word0 = '0;
    name_word1 = '0;
    name_word2 = '0;
    name_word3 = '0;
    strength   = '0;
    chan       = '0;
    sec_flags  = '0;

    for (int p = 0; p < POOL_N; p++) begin
      flat = '0;
      case (p)
        0: len = 32;
        1: len = 31;
        5: len = 1;
        default: len = ($urandom_range(0, 3) == 0) ? 32 : $urandom_range(1, 31);
      endcase
      for (int k = 0; k < len; k++) begin
        flat[8*k +: 8] = 8'($urandom_range(1, 255));
      end
      pool[p]     = flat;
      pool_len[p] = len;
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_cmd(tkds_pkg::ACT_DUMP);
    send_item(tkds_pkg::ACT_INSERT, dress_name('0, 0), 8'sd127, 8'hFF, 32'hFFFF_FFFF);
    send_cmd(ACT_UNUSED);
    send_cmd(tkds_pkg::ACT_DUMP);
    send_item(tkds_pkg::ACT_INSERT, pool[0], 8'sd127, 8'hFF, 32'hFFFF_FFFF);
    send_item(tkds_pkg::ACT_INSERT, pool[1], -8'sd128, 8'h00, 32'h0000_0000);
    send_item(tkds_pkg::ACT_INSERT, dress_name(pool[2], pool_len[2]), -8'sd128, 8'h5A,
              32'hA5A5_5A5A);
    insert_pool(3, 8'sd0);
    send_item(tkds_pkg::ACT_INSERT, dress_name(pool[1], pool_len[1]), -8'sd128, 8'hFF,
              32'hFFFF_FFFF);
    insert_pool(2, -8'sd5);
    insert_pool(3, -8'sd1);
    insert_pool(4, 8'sd127);
    insert_pool(5, 8'sd50);
    insert_pool(3, 8'sd127);
    send_cmd(tkds_pkg::ACT_DUMP);
    send_cmd(tkds_pkg::ACT_CLEAR);
    send_cmd(tkds_pkg::ACT_DUMP);
    insert_pool(6, 8'sd10);
    send_cmd(ACT_UNUSED);
    send_cmd(tkds_pkg::ACT_DUMP);
    send_cmd(tkds_pkg::ACT_CLEAR);

    while (n_sent < RANDOM_ITEMS) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 2) == 0) begin
        send_cmd(tkds_pkg::ACT_CLEAR);
      end
      n_ins = $urandom_range(3, 30);
      for (int k = 0; k < n_ins; k++) begin
        pick = $urandom_range(0, 19);
        s = ($urandom_range(0, 1) == 1) ? 8'($urandom) : 8'(int'($urandom_range(0, 6)) - 3);
        if (pick == 0) begin
          send_cmd(ACT_UNUSED);
        end else if (pick == 1) begin
          send_item(tkds_pkg::ACT_INSERT, dress_name('0, 0), s, 8'($urandom), $urandom);
        end else if (pick == 2) begin
          send_cmd(tkds_pkg::ACT_DUMP);
        end else begin
          insert_pool($urandom_range(0, POOL_N - 1), s);
        end
      end
      if (n_sent > 100 && !hold_req) begin
        hold_req = 1'b1;
      end
      send_cmd(tkds_pkg::ACT_DUMP);
    end

    gaps_on = 1'b0;
    send_cmd(tkds_pkg::ACT_CLEAR);
    for (int k = 0; k < 24; k++) begin
      insert_pool($urandom_range(0, POOL_N - 1), 8'($urandom));
    end
    send_cmd(tkds_pkg::ACT_DUMP);
    for (int k = 0; k < 8; k++) begin
      insert_pool($urandom_range(0, POOL_N - 1), 8'($urandom));
    end
    send_cmd(tkds_pkg::ACT_DUMP);
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
